@@ sv/i2c_sensor_measure_read_core_assert.svh @@
// Assertion macros shared by the sensor read core.
`ifndef I2C_SENSOR_MEASURE_READ_CORE_ASSERT_SVH
`define I2C_SENSOR_MEASURE_READ_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CSM_ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("i2c sensor read core: assertion failed");
`define I2CSM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("i2c sensor read core: forbidden condition seen");
`else
`define I2CSM_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define I2CSM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ sv/i2csm_pkg.sv @@
// Package with the phase codes, widths and reset values of the sensor read core.
package i2csm_pkg;

	localparam int unsigned READ_BYTE_COUNT = 6;
	localparam int unsigned PHASE_W = 5;
	localparam int unsigned TICK_W = 24;
	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned OUT_DATA_W = 56;
	localparam int unsigned RES_W = 53;

	localparam logic [PHASE_W-1:0] PH_IDLE      = 5'd0;
	localparam logic [PHASE_W-1:0] PH_START1    = 5'd1;
	localparam logic [PHASE_W-1:0] PH_START2    = 5'd2;
	localparam logic [PHASE_W-1:0] PH_START3    = 5'd3;
	localparam logic [PHASE_W-1:0] PH_TX_LOW    = 5'd4;
	localparam logic [PHASE_W-1:0] PH_TX_HIGH   = 5'd5;
	localparam logic [PHASE_W-1:0] PH_ACK_LOW   = 5'd6;
	localparam logic [PHASE_W-1:0] PH_ACK_HIGH  = 5'd7;
	localparam logic [PHASE_W-1:0] PH_RX_LOW    = 5'd8;
	localparam logic [PHASE_W-1:0] PH_RX_HIGH   = 5'd9;
	localparam logic [PHASE_W-1:0] PH_MACK_LOW  = 5'd10;
	localparam logic [PHASE_W-1:0] PH_MACK_HIGH = 5'd11;
	localparam logic [PHASE_W-1:0] PH_STOP1     = 5'd12;
	localparam logic [PHASE_W-1:0] PH_STOP2     = 5'd13;
	localparam logic [PHASE_W-1:0] PH_STOP3     = 5'd14;
	localparam logic [PHASE_W-1:0] PH_WAIT      = 5'd15;
	localparam logic [PHASE_W-1:0] PH_DONE      = 5'd16;

	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_MEASURE_COMMAND = 2'd1;
	localparam logic [1:0] REG_HALF_BIT_TICKS = 2'd2;
	localparam logic [1:0] REG_CONVERSION_WAIT = 2'd3;

	localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h44;
	localparam logic [7:0] MEASURE_COMMAND_RESET = 8'hFD;
	localparam logic [15:0] HALF_BIT_TICKS_RESET = 16'd2;
	localparam logic [23:0] CONVERSION_WAIT_RESET = 24'd20000;

	localparam logic [2:0] FIRST_READ_INDEX = 3'd2;
	localparam logic [2:0] LAST_READ_BYTE = 3'(READ_BYTE_COUNT);

	typedef struct packed {
		logic [7:0]  humidity_crc;
		logic [15:0] humidity_raw;
		logic [7:0]  temperature_crc;
		logic [15:0] temperature_raw;
		logic        missing_ack;
		logic        done_res;
		logic        busy_res;
		logic        sda_release;
		logic        scl_level;
	} result_t;

endpackage

@@ sv/i2c_sensor_measure_read_core.sv @@
// Top level of the bit-level I2C master that runs one sensor measurement per request.
//
// Each input item on the s_ channel is one bus timing tick carrying a start
// request and the sampled SDA level. For every accepted item the core returns
// exactly one result item on the m_ channel with the SCL and SDA pin levels for
// that tick, the busy and done flags, and on the done tick the raw temperature
// and humidity words, their CRC bytes and the missing ACK flag.
// A request while idle runs START, address write, command, STOP, the
// conversion wait unless it is zero, START, address read and six read bytes, then STOP.
// A result is registered and shown in the next cycle. One item is taken every cycle
// while results drain; sequencer state and result register update together.
// The result register frees the input side whenever it is empty or its item is
// taken in the same cycle, so a stalled receiver holds the result and stops
// the input until it is taken. Configuration writes on the cfg_ channel are
// always accepted and should only be made while the core is idle.
// Reset returns the sequencer to idle, clears the collected bytes and the
// ACK error flag, and loads the register defaults.
module i2c_sensor_measure_read_core
	import i2csm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// bit 0 start_request, bit 1 sda_sample, zero fill above
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// scl_level, sda_release, busy_res, done_res, missing_ack, temperature_raw,
	// temperature_crc, humidity_raw, humidity_crc from the lowest bit up, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [TICK_W-1:0]     cfg_data
);

`include "i2c_sensor_measure_read_core_assert.svh"

	logic [6:0]         device_address_q;
	logic [7:0]         measure_command_q;
	logic [15:0]        half_bit_ticks_q;
	logic [TICK_W-1:0]  conversion_wait_q;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [2:0]         bit_counter_q, bit_counter_d;
	logic [2:0]         byte_counter_q, byte_counter_d;
	logic [TICK_W-1:0]  tick_counter_q, tick_counter_d;
	logic [7:0]         shift_q, shift_d;
	logic [7:0]         rx_bytes_q [READ_BYTE_COUNT];
	logic               ack_error_q, ack_error_d;
	logic               rx_store;
	logic [7:0]         rx_shift_next;

	logic               m_valid_q;
	result_t            res_q, res_d;

	logic               s_accept;
	logic               start_req, sda_in;
	logic [15:0]        half_eff;
	logic [TICK_W:0]    tick_next;
	logic               phase_end, wait_end;
	logic               mack_rel;

	assign s_tready  = !m_valid_q || m_tready;
	assign s_accept  = s_tvalid && s_tready;
	assign start_req = s_tdata[0];
	assign sda_in    = s_tdata[1];
	assign cfg_ready = 1'b1;

	assign half_eff  = (half_bit_ticks_q == '0) ? 16'd1 : half_bit_ticks_q;
	assign tick_next = {1'b0, tick_counter_q} + (TICK_W+1)'(1);
	assign phase_end = tick_next >= (TICK_W+1)'(half_eff);
	assign wait_end  = tick_next >= {1'b0, conversion_wait_q};
	assign mack_rel  = !(byte_counter_q < LAST_READ_BYTE - 3'd1);
	assign rx_shift_next = {shift_q[6:0], sda_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q  <= DEVICE_ADDRESS_RESET;
			measure_command_q <= MEASURE_COMMAND_RESET;
			half_bit_ticks_q  <= HALF_BIT_TICKS_RESET;
			conversion_wait_q <= CONVERSION_WAIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS: device_address_q <= cfg_data[6:0];
				REG_MEASURE_COMMAND: measure_command_q <= cfg_data[7:0];
				REG_HALF_BIT_TICKS: half_bit_ticks_q <= cfg_data[15:0];
				REG_CONVERSION_WAIT: conversion_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		res_d = '0;
		res_d.scl_level   = 1'b1;
		res_d.sda_release = 1'b1;
		res_d.busy_res    = 1'b1;
		unique case (phase_q)
			PH_START2: res_d.sda_release = 1'b0;
			PH_START3: begin
				res_d.scl_level   = 1'b0;
				res_d.sda_release = 1'b0;
			end
			PH_TX_LOW: begin
				res_d.scl_level   = 1'b0;
				res_d.sda_release = shift_q[7];
			end
			PH_TX_HIGH: res_d.sda_release = shift_q[7];
			PH_ACK_LOW, PH_RX_LOW: res_d.scl_level = 1'b0;
			PH_MACK_LOW: begin
				res_d.scl_level   = 1'b0;
				res_d.sda_release = mack_rel;
			end
			PH_MACK_HIGH: res_d.sda_release = mack_rel;
			PH_STOP1: begin
				res_d.scl_level   = 1'b0;
				res_d.sda_release = 1'b0;
			end
			PH_STOP2: res_d.sda_release = 1'b0;
			default: ;
		endcase
		if (phase_q == PH_IDLE || phase_q > PH_DONE) begin
			res_d.busy_res = 1'b0;
		end else if (phase_q == PH_DONE) begin
			res_d.busy_res        = 1'b0;
			res_d.done_res        = 1'b1;
			res_d.missing_ack     = ack_error_q;
			res_d.temperature_raw = {rx_bytes_q[0], rx_bytes_q[1]};
			res_d.temperature_crc = rx_bytes_q[2];
			res_d.humidity_raw    = {rx_bytes_q[3], rx_bytes_q[4]};
			res_d.humidity_crc    = rx_bytes_q[5];
		end
	end

	always_comb begin
		phase_d        = phase_q;
		bit_counter_d  = bit_counter_q;
		byte_counter_d = byte_counter_q;
		tick_counter_d = tick_counter_q;
		shift_d        = shift_q;
		ack_error_d    = ack_error_q;
		rx_store       = 1'b0;
		if (phase_q == PH_IDLE || phase_q > PH_DONE) begin
			tick_counter_d = '0;
			if (start_req) begin
				bit_counter_d  = '0;
				byte_counter_d = '0;
				ack_error_d    = 1'b0;
				phase_d        = PH_START1;
			end else begin
				phase_d = PH_IDLE;
			end
		end else if (phase_q == PH_DONE) begin
			tick_counter_d = '0;
			phase_d        = PH_IDLE;
		end else if (phase_q == PH_WAIT) begin
			if (wait_end) begin
				tick_counter_d = '0;
				phase_d        = PH_START1;
			end else begin
				tick_counter_d = tick_next[TICK_W-1:0];
			end
		end else if (!phase_end) begin
			tick_counter_d = tick_next[TICK_W-1:0];
		end else begin
			tick_counter_d = '0;
			unique case (phase_q)
				PH_START1: phase_d = PH_START2;
				PH_START2: phase_d = PH_START3;
				PH_START3: begin
					shift_d       = {device_address_q, byte_counter_q != '0};
					bit_counter_d = '0;
					phase_d       = PH_TX_LOW;
				end
				PH_TX_LOW: phase_d = PH_TX_HIGH;
				PH_TX_HIGH: begin
					shift_d = {shift_q[6:0], 1'b0};
					if (bit_counter_q == 3'd7) begin
						bit_counter_d = '0;
						phase_d       = PH_ACK_LOW;
					end else begin
						bit_counter_d = bit_counter_q + 3'd1;
						phase_d       = PH_TX_LOW;
					end
				end
				PH_ACK_LOW: phase_d = PH_ACK_HIGH;
				PH_ACK_HIGH: begin
					if (sda_in) begin
						ack_error_d = 1'b1;
					end
					if (byte_counter_q == 3'd0) begin
						byte_counter_d = 3'd1;
						shift_d        = measure_command_q;
						bit_counter_d  = '0;
						phase_d        = PH_TX_LOW;
					end else if (byte_counter_q == 3'd1) begin
						phase_d = PH_STOP1;
					end else begin
						byte_counter_d = '0;
						shift_d        = '0;
						bit_counter_d  = '0;
						phase_d        = PH_RX_LOW;
					end
				end
				PH_RX_LOW: phase_d = PH_RX_HIGH;
				PH_RX_HIGH: begin
					shift_d = rx_shift_next;
					if (bit_counter_q == 3'd7) begin
						rx_store      = byte_counter_q < LAST_READ_BYTE;
						bit_counter_d = '0;
						phase_d       = PH_MACK_LOW;
					end else begin
						bit_counter_d = bit_counter_q + 3'd1;
						phase_d       = PH_RX_LOW;
					end
				end
				PH_MACK_LOW: phase_d = PH_MACK_HIGH;
				PH_MACK_HIGH: begin
					byte_counter_d = byte_counter_q + 3'd1;
					phase_d = (byte_counter_d >= LAST_READ_BYTE) ? PH_STOP1 : PH_RX_LOW;
				end
				PH_STOP1: phase_d = PH_STOP2;
				PH_STOP2: phase_d = PH_STOP3;
				PH_STOP3: begin
					if (byte_counter_q >= LAST_READ_BYTE) begin
						phase_d = PH_DONE;
					end else begin
						byte_counter_d = FIRST_READ_INDEX;
						phase_d = (conversion_wait_q == '0) ? PH_START1 : PH_WAIT;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bit_counter_q  <= '0;
			byte_counter_q <= '0;
			tick_counter_q <= '0;
			shift_q        <= '0;
			ack_error_q    <= 1'b0;
			for (int i = 0; i < READ_BYTE_COUNT; i++) begin
				rx_bytes_q[i] <= '0;
			end
		end else if (s_accept) begin
			phase_q        <= phase_d;
			bit_counter_q  <= bit_counter_d;
			byte_counter_q <= byte_counter_d;
			tick_counter_q <= tick_counter_d;
			shift_q        <= shift_d;
			ack_error_q    <= ack_error_d;
			if (rx_store) begin
				rx_bytes_q[byte_counter_q] <= rx_shift_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_DATA_W-RES_W)'(0), res_q};

	`I2CSM_ASSERT_IMPL(a_done_follows, clk, arst_n,
		(s_accept && phase_q == PH_DONE) |=> (m_valid_q && res_q.done_res && !res_q.busy_res))
	`I2CSM_ASSERT_IMPL(a_idle_stays, clk, arst_n,
		(s_accept && phase_q == PH_IDLE && !start_req) |=> (phase_q == PH_IDLE))
	`I2CSM_ASSERT_NEVER(a_data_outside_done, clk, arst_n,
		m_valid_q && !res_q.done_res && (res_q.missing_ack || res_q.temperature_raw != '0))
	`I2CSM_ASSERT_NEVER(a_byte_count_range, clk, arst_n, byte_counter_q > LAST_READ_BYTE)

endmodule

@@ tb/sv/i2c_read_sb_pkg.sv @@
// Scoreboard for the sensor read core: bus sequencer predictor and per-tick result checker.
package i2c_read_sb_pkg;
	import i2csm_pkg::*;

	class i2c_read_scoreboard;
		logic [6:0] dev_addr;
		logic [7:0] command;
		logic [15:0] half_ticks;
		logic [23:0] conv_wait;

		logic [PHASE_W-1:0] phase;
		logic [2:0] bit_cnt;
		logic [2:0] byte_cnt;
		logic [TICK_W-1:0] tick_cnt;
		logic [7:0] shreg;
		logic [7:0] rx_bytes [READ_BYTE_COUNT];
		logic ack_err;

		result_t expected_pins[$];
		int mismatches;

		function new();
			dev_addr = DEVICE_ADDRESS_RESET;
			command = MEASURE_COMMAND_RESET;
			half_ticks = HALF_BIT_TICKS_RESET;
			conv_wait = CONVERSION_WAIT_RESET;
			phase = PH_IDLE;
			bit_cnt = '0;
			byte_cnt = '0;
			tick_cnt = '0;
			shreg = '0;
			foreach (rx_bytes[i]) rx_bytes[i] = '0;
			ack_err = 1'b0;
			mismatches = 0;
		endfunction

		function void apply_reg(logic [1:0] idx, logic [TICK_W-1:0] val);
			case (idx)
				REG_DEVICE_ADDRESS: dev_addr = val[6:0];
				REG_MEASURE_COMMAND: command = val[7:0];
				REG_HALF_BIT_TICKS: half_ticks = val[15:0];
				REG_CONVERSION_WAIT: conv_wait = val[23:0];
				default: ;
			endcase
		endfunction

		function void enter(logic [PHASE_W-1:0] next);
			phase = next;
			tick_cnt = '0;
		endfunction

		function result_t advance_bus(bit req, bit sda);
			result_t r;
			int unsigned h;
			logic master_nack;
			r = '0;
			r.scl_level = 1'b1;
			r.sda_release = 1'b1;
			r.busy_res = 1'b1;
			h = (half_ticks == 0) ? 1 : half_ticks;
			master_nack = !((int'(byte_cnt) + 1) < READ_BYTE_COUNT);
			case (phase)
				PH_START2: r.sda_release = 1'b0;
				PH_START3: begin
					r.scl_level = 1'b0;
					r.sda_release = 1'b0;
				end
				PH_TX_LOW: begin
					r.scl_level = 1'b0;
					r.sda_release = shreg[7];
				end
				PH_TX_HIGH: r.sda_release = shreg[7];
				PH_ACK_LOW, PH_RX_LOW: r.scl_level = 1'b0;
				PH_MACK_LOW: begin
					r.scl_level = 1'b0;
					r.sda_release = master_nack;
				end
				PH_MACK_HIGH: r.sda_release = master_nack;
				PH_STOP1: begin
					r.scl_level = 1'b0;
					r.sda_release = 1'b0;
				end
				PH_STOP2: r.sda_release = 1'b0;
				default: ;
			endcase

			if (phase == PH_IDLE || phase > PH_DONE) begin
				r.busy_res = 1'b0;
				if (req) begin
					bit_cnt = '0;
					byte_cnt = '0;
					ack_err = 1'b0;
					enter(PH_START1);
				end else begin
					enter(PH_IDLE);
				end
			end else if (phase == PH_DONE) begin
				r.busy_res = 1'b0;
				r.done_res = 1'b1;
				r.missing_ack = ack_err;
				r.temperature_raw = {rx_bytes[0], rx_bytes[1]};
				r.temperature_crc = rx_bytes[2];
				r.humidity_raw = {rx_bytes[3], rx_bytes[4]};
				r.humidity_crc = rx_bytes[5];
				enter(PH_IDLE);
			end else if (phase == PH_WAIT) begin
				if (int'(tick_cnt) + 1 >= int'(conv_wait)) enter(PH_START1);
				else tick_cnt++;
			end else if (int'(tick_cnt) + 1 >= h) begin
				case (phase)
					PH_START1: enter(PH_START2);
					PH_START2: enter(PH_START3);
					PH_START3: begin
						shreg = {dev_addr, byte_cnt != 0};
						bit_cnt = '0;
						enter(PH_TX_LOW);
					end
					PH_TX_LOW: enter(PH_TX_HIGH);
					PH_TX_HIGH: begin
						shreg = {shreg[6:0], 1'b0};
						if (bit_cnt >= 7) begin
							bit_cnt = '0;
							enter(PH_ACK_LOW);
						end else begin
							bit_cnt++;
							enter(PH_TX_LOW);
						end
					end
					PH_ACK_LOW: enter(PH_ACK_HIGH);
					PH_ACK_HIGH: begin
						if (sda) ack_err = 1'b1;
						if (byte_cnt == 0) begin
							byte_cnt = 3'd1;
							shreg = command;
							bit_cnt = '0;
							enter(PH_TX_LOW);
						end else if (byte_cnt == 1) begin
							enter(PH_STOP1);
						end else begin
							byte_cnt = '0;
							shreg = '0;
							bit_cnt = '0;
							enter(PH_RX_LOW);
						end
					end
					PH_RX_LOW: enter(PH_RX_HIGH);
					PH_RX_HIGH: begin
						shreg = {shreg[6:0], sda};
						if (bit_cnt >= 7) begin
							if (byte_cnt < READ_BYTE_COUNT) rx_bytes[byte_cnt] = shreg;
							bit_cnt = '0;
							enter(PH_MACK_LOW);
						end else begin
							bit_cnt++;
							enter(PH_RX_LOW);
						end
					end
					PH_MACK_LOW: enter(PH_MACK_HIGH);
					PH_MACK_HIGH: begin
						byte_cnt = byte_cnt + 3'd1;
						if (byte_cnt >= READ_BYTE_COUNT) enter(PH_STOP1);
						else enter(PH_RX_LOW);
					end
					PH_STOP1: enter(PH_STOP2);
					PH_STOP2: enter(PH_STOP3);
					PH_STOP3: begin
						if (byte_cnt >= READ_BYTE_COUNT) begin
							enter(PH_DONE);
						end else begin
							byte_cnt = FIRST_READ_INDEX;
							enter(conv_wait == 0 ? PH_START1 : PH_WAIT);
						end
					end
					default: enter(PH_IDLE);
				endcase
			end else begin
				tick_cnt++;
			end
			return r;
		endfunction

		function void note_tick(bit req, bit sda);
			expected_pins.push_back(advance_bus(req, sda));
		endfunction

		function void check_pins(logic [OUT_DATA_W-1:0] data);
			result_t got;
			result_t want;
			got = data[RES_W-1:0];
			if (expected_pins.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item %h", data);
				return;
			end
			want = expected_pins.pop_front();
			if (got.scl_level !== want.scl_level || got.sda_release !== want.sda_release ||
					got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
					got.missing_ack !== want.missing_ack ||
					got.temperature_raw !== want.temperature_raw ||
					got.temperature_crc !== want.temperature_crc ||
					got.humidity_raw !== want.humidity_raw ||
					got.humidity_crc !== want.humidity_crc ||
					data[OUT_DATA_W-1:RES_W] !== '0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("expected scl %b sda %b busy %b done %b nack %b t %h/%h h %h/%h",
						want.scl_level, want.sda_release, want.busy_res, want.done_res,
						want.missing_ack, want.temperature_raw, want.temperature_crc,
						want.humidity_raw, want.humidity_crc);
					$display("actual   scl %b sda %b busy %b done %b nack %b t %h/%h h %h/%h fill %b",
						got.scl_level, got.sda_release, got.busy_res, got.done_res,
						got.missing_ack, got.temperature_raw, got.temperature_crc,
						got.humidity_raw, got.humidity_crc, data[OUT_DATA_W-1:RES_W]);
				end
			end
		endfunction
	endclass

endpackage

@@ tb/sv/tb_i2c_sensor_measure_read_core.sv @@
// Testbench top for the sensor read core: drives bus ticks and checks every pin result.
module tb_i2c_sensor_measure_read_core;
	timeunit 1ns;
	timeprecision 1ps;
	import i2csm_pkg::*;
	import i2c_read_sb_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [TICK_W-1:0] cfg_data;

	int send_idle;
	int recv_idle;
	i2c_read_scoreboard sb = new();

	i2c_sensor_measure_read_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_pins(m_tdata);
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// The slave mostly acknowledges; the rest of the time it leaves SDA high.
	function automatic bit pick_sda();
		if (sb.phase == PH_ACK_HIGH) return ($urandom_range(99) < 15);
		return bit'($urandom_range(1));
	endfunction

	task automatic send_tick(input bit req, input bit sda);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W-2){1'b0}}, sda, req};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(req, sda);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_pins.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		while (sb.phase != PH_IDLE) send_tick(bit'($urandom_range(1)), pick_sda());
		hold_until_drained();
	endtask

	task automatic configure(input logic [6:0] addr, input logic [7:0] cmd,
			input logic [15:0] half, input logic [23:0] conv);
		logic [31:0] junk;
		logic [TICK_W-1:0] vals [4];
		logic [1:0] idx [4];
		junk = $urandom;
		idx = '{REG_DEVICE_ADDRESS, REG_MEASURE_COMMAND, REG_HALF_BIT_TICKS, REG_CONVERSION_WAIT};
		vals = '{{junk[23:7], addr}, {junk[23:8], cmd}, {junk[31:24], half}, conv};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.apply_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_traffic(input int n);
		int pause_at;
		pause_at = $urandom_range(n - 1);
		for (int i = 0; i < n; i++) begin
			bit req;
			if (i == pause_at) hold_until_drained();
			if (sb.phase == PH_IDLE || sb.phase == PH_DONE) req = ($urandom_range(99) < 40);
			else req = bit'($urandom_range(1));
			send_tick(req, pick_sda());
		end
	endtask

	task automatic traffic_phase(input logic [6:0] addr, input logic [7:0] cmd,
			input logic [15:0] half, input logic [23:0] conv);
		configure(addr, cmd, half, conv);
		run_traffic(60);
		settle();
	endtask

	initial begin
		#100_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEVICE_ADDRESS;
		cfg_data = '0;
		send_idle = 20;
		recv_idle = 65;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Idle ticks right after reset with both lines released.
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		settle();

		traffic_phase(7'd0, 8'd0, 16'd0, 24'd0);

		send_idle = 65;
		recv_idle = 20;
		traffic_phase(7'd127, 8'd255, 16'd1, 24'($urandom_range(1, 40)));

		send_idle = 0;
		recv_idle = 0;
		traffic_phase(7'($urandom_range(127)), 8'($urandom_range(255)), 16'd1, 24'd5);

		// Largest timing values; the transaction is still running when stimulus ends.
		configure(7'($urandom_range(127)), 8'($urandom_range(255)), 16'hFFFF, 24'hFFFFFF);
		run_traffic(40);
		hold_until_drained();
		repeat (4) @(posedge clk);

		sb.mismatches += sb.expected_pins.size();
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
